>>> hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared widths, status codes, state type and payload records.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int BLOCKS    = 256;
    localparam int MAX_PAGES = 64;
    localparam int JOBS      = 16;

    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int JOB_W  = $clog2(JOBS);
    localparam int CNT_W  = BLK_W + 1;
    localparam int PT_W   = JOB_W + PAGE_W;

    localparam logic [2:0] ST_PLACED   = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_NOT_FND  = 3'd2;
    localparam logic [2:0] ST_RECYCLED = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RECYCLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [3:0] job_id;
        logic [6:0] page_count;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] page_index;
        logic [7:0] block_index;
        logic [8:0] free_count;
        logic       last;
    } t_rsp;

endpackage

>>> hw/rtl/bpa_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one allocate or recycle word.
// ----------------------------------------------------------------------------
interface bpa_req_if;
    import bpa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bpa_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
    import bpa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/bpa_ptab.sv
// ----------------------------------------------------------------------------
// Page table memory
// One write and one registered read per cycle; contents undefined after reset.
// ----------------------------------------------------------------------------
module bpa_ptab (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [bpa_pkg::PT_W-1:0]  i_waddr,
    input  logic [bpa_pkg::BLK_W-1:0] i_wdata,
    input  logic [bpa_pkg::PT_W-1:0]  i_raddr,
    output logic [bpa_pkg::BLK_W-1:0] o_rdata
);
    import bpa_pkg::*;

    logic [BLK_W-1:0] r_mem [JOBS*MAX_PAGES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/bitmap_page_allocator.sv
// Allocate scans one block per cycle from block 0 until the request is filled,
// then gives one result word per placed page.
// Recycle walks the job's page table, reading each page's block and then clearing its bit, then gives one word.
// Rejected requests give a single word; one request at a time.
// Reset is synchronous active low; the bitmap clears at once and all slots
// are empty, and a block_count write reinitializes the same way.
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Sequencer driving a shared block cursor over the occupancy bitmap.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp
);
    import bpa_pkg::*;

    t_state             r_state, n_state;
    logic [BLOCKS-1:0]  r_used;
    logic [CNT_W-1:0]   r_lim;
    logic [CNT_W-1:0]   r_free;
    logic [JOBS-1:0]    r_jvalid;
    logic [6:0]         r_jpages [JOBS];
    t_req               r_req;
    logic [CNT_W-1:0]   r_cur;
    logic [6:0]         r_placed;
    logic [6:0]         r_oidx;
    logic [2:0]         r_status;
    logic               r_rd_d;

    logic               ptab_we;
    logic [PT_W-1:0]    ptab_waddr, ptab_raddr;
    logic [BLK_W-1:0]   ptab_rdata;
    logic               accept;
    logic [2:0]         rej_status;
    logic               rsp_fire;

    assign accept   = i_req.valid && i_req.ready;
    assign rsp_fire = o_rsp.valid && o_rsp.ready;

    bpa_ptab u_ptab (
        .i_clk  (i_clk),
        .i_we   (ptab_we),
        .i_waddr(ptab_waddr),
        .i_wdata(r_cur[BLK_W-1:0]),
        .i_raddr(ptab_raddr),
        .o_rdata(ptab_rdata)
    );

    always_comb begin
        rej_status = ST_PLACED;
        if (i_req.data.kind == KIND_RECYCLE) begin
            if (!r_jvalid[i_req.data.job_id]) begin
                rej_status = ST_NOT_FND;
            end else begin
                rej_status = ST_RECYCLED;
            end
        end else if (r_jvalid[i_req.data.job_id]) begin
            rej_status = ST_BUSY;
        end else if (i_req.data.page_count == 7'd0
                     || 32'(i_req.data.page_count) > MAX_PAGES
                     || CNT_W'(i_req.data.page_count) > r_free) begin
            rej_status = ST_NO_SPACE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (rej_status == ST_PLACED) begin
                        n_state = S_SCAN;
                    end else if (rej_status == ST_RECYCLED) begin
                        n_state = S_FREE_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN: begin
                if (!r_used[r_cur[BLK_W-1:0]] && r_placed + 7'd1 == r_req.page_count) begin
                    n_state = S_OUT;
                end
            end
            S_FREE_RD: begin
                if (r_cur[6:0] == r_jpages[r_req.job_id]) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_FREE_WR;
                end
            end
            S_FREE_WR: n_state = S_FREE_RD;
            S_OUT: begin
                if (rsp_fire && (r_status != ST_PLACED || r_oidx + 7'd1 == r_placed)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE) && !i_cfg_we;
        o_rsp.valid = (r_state == S_OUT) && !r_rd_d;
        ptab_we     = (r_state == S_SCAN) && !r_used[r_cur[BLK_W-1:0]];
        ptab_waddr  = {r_req.job_id, r_placed[PAGE_W-1:0]};
        ptab_raddr  = {r_req.job_id, (r_state == S_OUT) ? r_oidx[PAGE_W-1:0]
                                                         : r_cur[PAGE_W-1:0]};
        o_rsp.data.status      = r_status;
        o_rsp.data.page_index  = (r_status == ST_PLACED) ? r_oidx[5:0] : 6'd0;
        o_rsp.data.block_index = (r_status == ST_PLACED) ? ptab_rdata : 8'd0;
        o_rsp.data.free_count  = r_free;
        o_rsp.data.last        = (r_status != ST_PLACED) || (r_oidx + 7'd1 == r_placed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_jvalid <= '0;
            for (int j = 0; j < JOBS; j++) r_jpages[j] <= 7'd0;
            if (!i_rst_n) begin
                r_lim  <= CNT_W'(BLOCKS);
                r_free <= CNT_W'(BLOCKS);
            end else begin
                r_lim  <= (32'(i_cfg_data) > BLOCKS) ? CNT_W'(BLOCKS) : i_cfg_data;
                r_free <= (32'(i_cfg_data) > BLOCKS) ? CNT_W'(BLOCKS) : i_cfg_data;
            end
            r_rd_d <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_d  <= (n_state == S_OUT) && (r_state != S_OUT || rsp_fire);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req.data;
                        r_status <= rej_status;
                        r_cur    <= '0;
                        r_placed <= 7'd0;
                        r_oidx   <= 7'd0;
                    end
                end
                S_SCAN: begin
                    if (!r_used[r_cur[BLK_W-1:0]]) begin
                        r_used[r_cur[BLK_W-1:0]] <= 1'b1;
                        r_placed <= r_placed + 7'd1;
                        if (r_placed + 7'd1 == r_req.page_count) begin
                            r_free <= r_free - CNT_W'(r_req.page_count);
                            r_jvalid[r_req.job_id] <= 1'b1;
                            r_jpages[r_req.job_id] <= r_req.page_count;
                        end
                    end
                    r_cur <= r_cur + CNT_W'(1);
                end
                S_FREE_RD: begin
                    if (r_cur[6:0] == r_jpages[r_req.job_id]) begin
                        r_free <= r_free + CNT_W'(r_jpages[r_req.job_id]);
                        r_jvalid[r_req.job_id] <= 1'b0;
                        r_jpages[r_req.job_id] <= 7'd0;
                    end
                end
                S_FREE_WR: begin
                    r_used[ptab_rdata] <= 1'b0;
                    r_cur <= r_cur + CNT_W'(1);
                end
                S_OUT: begin
                    if (rsp_fire) begin
                        r_oidx <= r_oidx + 7'd1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_lim) else $error("free count above block count");
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cur < r_lim) else $error("scan ran past last block");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_req.ready) else $error("ready while busy");
    a_out_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> r_state == S_OUT) else $error("word outside output state");
`endif
endmodule
